>>> rtl/atwc_pkg.sv
// ----------------------------------------------------------------------------
// atwc_pkg
// Types and constants shared by the temperature window classifier modules.
// ----------------------------------------------------------------------------
package atwc_pkg;

  localparam int RAW_W    = 32;
  localparam int CODE_LSB = 4;
  localparam int CODE_W   = 12;
  localparam int V_W      = 16;
  localparam int TEMP_W   = 7;
  localparam int SUM_W    = 14;
  localparam int CNT_W    = 7;
  localparam int DAC_W    = 10;
  localparam int LED_W    = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_DAC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_DAC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_DAC    = 3'd4;

  localparam logic [TEMP_W-1:0] HIGH_LIMIT_RST = 7'd70;
  localparam logic [TEMP_W-1:0] MID_LIMIT_RST  = 7'd50;
  localparam logic [DAC_W-1:0]  HIGH_DAC_RST   = 10'd1023;
  localparam logic [DAC_W-1:0]  MID_DAC_RST    = 10'd605;
  localparam logic [DAC_W-1:0]  LOW_DAC_RST    = 10'd0;

  // Threshold table of the scaled code v = code * 10.
  localparam logic [V_W-1:0] V_T10  = 16'd1242;
  localparam logic [V_W-1:0] V_T11  = 16'd1365;
  localparam logic [V_W-1:0] V_T12  = 16'd1488;
  localparam logic [V_W-1:0] V_T13  = 16'd1611;
  localparam logic [V_W-1:0] V_T14  = 16'd1735;
  localparam logic [V_W-1:0] V_BASE = 16'd1243;
  localparam logic [V_W-1:0] V_TOP  = 16'd12435;

  localparam logic [TEMP_W-1:0] TEMP_OUT  = 7'd1;
  localparam logic [TEMP_W-1:0] TEMP_T10  = 7'd10;
  localparam logic [TEMP_W-1:0] TEMP_T11  = 7'd11;
  localparam logic [TEMP_W-1:0] TEMP_T12  = 7'd12;
  localparam logic [TEMP_W-1:0] TEMP_T13  = 7'd13;

  // Division by the step of 123 as a reciprocal multiply, exact for x < 2^14.
  localparam int              CLS_X_W     = 14;
  localparam int              CLS_RECIP_W = 15;
  localparam logic [CLS_RECIP_W-1:0] CLS_RECIP = 15'd17051;
  localparam int              CLS_SHIFT   = 21;

  // Division of the window sum by the window length.
  localparam int RECIP_W   = 22;
  localparam int DIV_SHIFT = 21;

  // Queue between the front and the back part.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [LED_W-1:0] {
    LED_NONE = 2'd0,
    LED_LOW  = 2'd1,
    LED_MID  = 2'd2,
    LED_HIGH = 2'd3
  } led_t;

  typedef struct packed {
    logic              valid;
    logic [TEMP_W-1:0] temp;
  } temp_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] high_limit;
    logic [TEMP_W-1:0] mid_limit;
    logic [DAC_W-1:0]  high_dac;
    logic [DAC_W-1:0]  mid_dac;
    logic [DAC_W-1:0]  low_dac;
  } band_cfg_t;

endpackage

>>> rtl/adc_temperature_window_classifier.sv
// ----------------------------------------------------------------------------
// adc_temperature_window_classifier
// Maps converter words to temperatures, averages them over a window and
// holds the band's analog code and indicator until the next window closes.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, the queue, the
// accumulate stage, the divide stage and the result register, in that order.
// Throughput: one item per cycle while out_stall is low; the divide and
// threshold multipliers are each one registered stage, so nothing iterates.
// Reset clears the pipeline, queue, window sum, held outputs and restores
// the configuration registers to their default values.
module adc_temperature_window_classifier #(
  parameter int WINDOW = 100
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [atwc_pkg::RAW_W-1:0]      in_raw_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [atwc_pkg::TEMP_W-1:0]     out_sample_temp,
  output logic                            out_window_done,
  output logic [atwc_pkg::TEMP_W-1:0]     out_avg_temp,
  output logic [atwc_pkg::DAC_W-1:0]      out_dac_code,
  output logic [atwc_pkg::LED_W-1:0]      out_led_select,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [atwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atwc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import atwc_pkg::*;

  band_cfg_t         cfg_r, cfg_nxt;
  temp_item_t        push;
  temp_item_t        head;
  logic              pop;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIGH_LIMIT: cfg_nxt.high_limit = cfg_data[TEMP_W-1:0];
        REG_MID_LIMIT:  cfg_nxt.mid_limit  = cfg_data[TEMP_W-1:0];
        REG_HIGH_DAC:   cfg_nxt.high_dac   = cfg_data[DAC_W-1:0];
        REG_MID_DAC:    cfg_nxt.mid_dac    = cfg_data[DAC_W-1:0];
        REG_LOW_DAC:    cfg_nxt.low_dac    = cfg_data[DAC_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_limit <= HIGH_LIMIT_RST;
      cfg_r.mid_limit  <= MID_LIMIT_RST;
      cfg_r.high_dac   <= HIGH_DAC_RST;
      cfg_r.mid_dac    <= MID_DAC_RST;
      cfg_r.low_dac    <= LOW_DAC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  atwc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_word (in_raw_word),
    .q_count     (q_count),
    .push        (push)
  );

  atwc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  atwc_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .band_cfg        (cfg_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_temp (out_sample_temp),
    .out_window_done (out_window_done),
    .out_avg_temp    (out_avg_temp),
    .out_dac_code    (out_dac_code),
    .out_led_select  (out_led_select)
  );

endmodule

>>> rtl/atwc_front.sv
// ----------------------------------------------------------------------------
// atwc_front
// Accepts converter words, scales the code by ten and maps it to a
// temperature, then pushes the temperature into the queue.
// ----------------------------------------------------------------------------
module atwc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [atwc_pkg::RAW_W-1:0]  in_raw_word,
  input  logic [atwc_pkg::QCNT_W-1:0] q_count,
  output atwc_pkg::temp_item_t        push
);
  import atwc_pkg::*;

  logic                   f1_v_r, f1_v_nxt;
  logic [V_W-1:0]         f1_val_r;
  logic [CODE_W-1:0]      code;
  logic [V_W-1:0]         scaled;
  logic [CLS_X_W-1:0]     x;
  logic [CLS_X_W+CLS_RECIP_W-1:0] prod;
  logic [TEMP_W-1:0]      temp;
  logic                   accept;

  // The registered item always finds room, since the stall counts it as well.
  assign in_stall = ({1'b0, q_count} + {{QCNT_W{1'b0}}, f1_v_r}) >= (QCNT_W+1)'(QDEPTH);
  assign accept   = in_valid && !in_stall;
  assign f1_v_nxt = accept;

  assign code   = in_raw_word[CODE_LSB +: CODE_W];
  assign scaled = {1'b0, code, 3'b000} + {3'b000, code, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_val_r <= scaled;
    end
  end

  // From 14 degrees upward the steps are a uniform 123 apart.
  assign x    = CLS_X_W'(f1_val_r - V_BASE);
  assign prod = x * CLS_RECIP;

  always_comb begin
    if (f1_val_r < V_T10 || f1_val_r >= V_TOP) begin
      temp = TEMP_OUT;
    end else if (f1_val_r < V_T11) begin
      temp = TEMP_T10;
    end else if (f1_val_r < V_T12) begin
      temp = TEMP_T11;
    end else if (f1_val_r < V_T13) begin
      temp = TEMP_T12;
    end else if (f1_val_r < V_T14) begin
      temp = TEMP_T13;
    end else begin
      temp = TEMP_T10 + prod[CLS_SHIFT +: TEMP_W];
    end
  end

  assign push.valid = f1_v_r;
  assign push.temp  = temp;

endmodule

>>> rtl/atwc_queue.sv
// ----------------------------------------------------------------------------
// atwc_queue
// Short FIFO of sample temperatures between the front and the back part.
// ----------------------------------------------------------------------------
module atwc_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  atwc_pkg::temp_item_t        push,
  input  logic                        pop,
  output atwc_pkg::temp_item_t        head,
  output logic [atwc_pkg::QCNT_W-1:0] count
);
  import atwc_pkg::*;

  logic [TEMP_W-1:0] mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(QCNT_W-1){1'b0}}, push.valid}
                         - {{(QCNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.temp;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.temp  = mem[rd_ptr_r];
  assign count      = count_r;

endmodule

>>> rtl/atwc_back.sv
// ----------------------------------------------------------------------------
// atwc_back
// Sums temperatures over the window, divides the closing sum by the window
// length, selects the band and drives the result register.
// ----------------------------------------------------------------------------
module atwc_back #(
  parameter int WINDOW = 100
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  atwc_pkg::temp_item_t        head,
  output logic                        pop,
  input  atwc_pkg::band_cfg_t         band_cfg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [atwc_pkg::TEMP_W-1:0] out_sample_temp,
  output logic                        out_window_done,
  output logic [atwc_pkg::TEMP_W-1:0] out_avg_temp,
  output logic [atwc_pkg::DAC_W-1:0]  out_dac_code,
  output logic [atwc_pkg::LED_W-1:0]  out_led_select
);
  import atwc_pkg::*;

  localparam logic [RECIP_W-1:0] Recip =
    RECIP_W'((2 ** DIV_SHIFT + WINDOW - 1) / WINDOW);

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_add;
  logic              closes;

  logic              b1_v_r;
  logic [TEMP_W-1:0] b1_temp_r;
  logic              b1_done_r;
  logic [SUM_W-1:0]  b1_sum_r;

  logic              b2_v_r;
  logic [TEMP_W-1:0] b2_temp_r;
  logic              b2_done_r;
  logic [SUM_W-1:0]  b2_avg_r;

  logic              out_v_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic              out_done_r;
  logic [TEMP_W-1:0] out_avg_r;
  logic [DAC_W-1:0]  out_dac_r;
  led_t              out_led_r;

  logic [SUM_W+RECIP_W-1:0] prod;
  logic              out_free, b2_free, b1_free, b2_adv, b1_adv;
  logic [DAC_W-1:0]  band_dac;
  led_t              band_led;

  assign out_free = !out_v_r || !out_stall;
  assign b2_adv   = b2_v_r && out_free;
  assign b2_free  = !b2_v_r || out_free;
  assign b1_adv   = b1_v_r && b2_free;
  assign b1_free  = !b1_v_r || b2_free;
  assign pop      = head.valid && b1_free;

  // Accumulate at the pop; a closing item hands its sum on and restarts.
  assign sum_add = sum_r + {{(SUM_W-TEMP_W){1'b0}}, head.temp};
  assign closes  = (cnt_r + 1'b1) == CNT_W'(WINDOW);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      sum_nxt = closes ? '0 : sum_add;
      cnt_nxt = closes ? '0 : cnt_r + 1'b1;
    end
  end

  assign prod = b1_sum_r * Recip;

  always_comb begin
    if (b2_avg_r >= {{(SUM_W-TEMP_W){1'b0}}, band_cfg.high_limit}) begin
      band_dac = band_cfg.high_dac;
      band_led = LED_HIGH;
    end else if (b2_avg_r >= {{(SUM_W-TEMP_W){1'b0}}, band_cfg.mid_limit}) begin
      band_dac = band_cfg.mid_dac;
      band_led = LED_MID;
    end else begin
      band_dac = band_cfg.low_dac;
      band_led = LED_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      cnt_r      <= '0;
      b1_v_r     <= 1'b0;
      b2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      out_avg_r  <= '0;
      out_dac_r  <= '0;
      out_led_r  <= LED_NONE;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      if (b1_free) begin
        b1_v_r <= pop;
      end
      if (b2_free) begin
        b2_v_r <= b1_v_r;
      end
      if (out_free) begin
        out_v_r <= b2_v_r;
      end
      // The held fields keep their value until a window closes.
      if (b2_adv && b2_done_r) begin
        out_avg_r <= b2_avg_r[TEMP_W-1:0];
        out_dac_r <= band_dac;
        out_led_r <= band_led;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_temp_r <= head.temp;
      b1_done_r <= closes;
      b1_sum_r  <= sum_add;
    end
    if (b1_adv) begin
      b2_temp_r <= b1_temp_r;
      b2_done_r <= b1_done_r;
      b2_avg_r  <= prod[DIV_SHIFT +: SUM_W];
    end
    if (b2_adv) begin
      out_temp_r <= b2_temp_r;
      out_done_r <= b2_done_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_sample_temp = out_temp_r;
  assign out_window_done = out_done_r;
  assign out_avg_temp    = out_avg_r;
  assign out_dac_code    = out_dac_r;
  assign out_led_select  = out_led_r;

endmodule
